### src/utf8_stream_validator_assert.svh
// ----------------------------------------------------------------------------
// utf8_stream_validator_assert.svh
// assertion macros shared by the checker files of the validator
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define U8SV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define U8SV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/u8sv_pkg.sv
// ----------------------------------------------------------------------------
// u8sv_pkg
// types, byte constants and the second-byte floor table of the validator
// ----------------------------------------------------------------------------
package u8sv_pkg;

    // continuation byte mask and pattern
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_PAT  = 8'h80;

    // lead byte boundaries
    localparam logic [7:0] LEAD_ASCII_END = 8'h80;
    localparam logic [7:0] LEAD_MIN       = 8'hC2;
    localparam logic [7:0] LEAD_3B        = 8'hE0;
    localparam logic [7:0] LEAD_4B        = 8'hF0;
    localparam logic [7:0] LEAD_5B        = 8'hF8;
    localparam logic [7:0] LEAD_6B        = 8'hFC;
    localparam logic [7:0] LEAD_BAD       = 8'hFE;

    // floor values on the second byte
    localparam logic [7:0] FLOOR_VAL_A0 = 8'hA0;
    localparam logic [7:0] FLOOR_VAL_90 = 8'h90;
    localparam logic [7:0] FLOOR_VAL_88 = 8'h88;
    localparam logic [7:0] FLOOR_VAL_84 = 8'h84;

    // widths of fixed fields
    localparam int unsigned CNT_BITS = 3;
    localparam int unsigned OUT_OFFSET_BITS = 16;

    typedef enum logic [2:0] {
        FLOOR_NONE = 3'd0,
        FLOOR_A0   = 3'd1,
        FLOOR_90   = 3'd2,
        FLOOR_88   = 3'd3,
        FLOOR_84   = 3'd4
    } t_floor;

    // sequence state carried from byte to byte
    typedef struct packed {
        logic [CNT_BITS-1:0] remaining;
        t_floor              floor_code;
    } t_seq_state;

    // floor code to minimum byte value
    function automatic logic [7:0] floor_value(input t_floor code);
        logic [7:0] v;
        case (code)
            FLOOR_A0: v = FLOOR_VAL_A0;
            FLOOR_90: v = FLOOR_VAL_90;
            FLOOR_88: v = FLOOR_VAL_88;
            FLOOR_84: v = FLOOR_VAL_84;
            default:  v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

### src/u8sv_decode.sv
// ----------------------------------------------------------------------------
// u8sv_decode
// combinational check of one byte against the pending sequence state
// ----------------------------------------------------------------------------
module u8sv_decode (
    input  logic [7:0]           i_data_byte,
    input  u8sv_pkg::t_seq_state i_state,
    output logic                 o_err,
    output u8sv_pkg::t_seq_state o_state
);
    import u8sv_pkg::*;

    logic       lead_err;
    t_seq_state lead_state;
    logic       cont_err;
    t_seq_state cont_state;

    // lead byte: length and floor from the byte range
    always_comb begin
        lead_err   = 1'b0;
        lead_state = '{remaining: '0, floor_code: FLOOR_NONE};
        if (i_data_byte < LEAD_ASCII_END) begin
            lead_state.remaining = 3'd0;
        end else if (i_data_byte < LEAD_MIN) begin
            lead_err = 1'b1;
        end else if (i_data_byte < LEAD_3B) begin
            lead_state.remaining = 3'd1;
        end else if (i_data_byte < LEAD_4B) begin
            lead_state.remaining = 3'd2;
            if (i_data_byte == LEAD_3B) lead_state.floor_code = FLOOR_A0;
        end else if (i_data_byte < LEAD_5B) begin
            lead_state.remaining = 3'd3;
            if (i_data_byte == LEAD_4B) lead_state.floor_code = FLOOR_90;
        end else if (i_data_byte < LEAD_6B) begin
            lead_state.remaining = 3'd4;
            if (i_data_byte == LEAD_5B) lead_state.floor_code = FLOOR_88;
        end else if (i_data_byte < LEAD_BAD) begin
            lead_state.remaining = 3'd5;
            if (i_data_byte == LEAD_6B) lead_state.floor_code = FLOOR_84;
        end else begin
            lead_err = 1'b1;
        end
    end

    // continuation byte: pattern and floor check
    always_comb begin
        cont_err   = ((i_data_byte & CONT_MASK) != CONT_PAT) ||
                     (i_data_byte < floor_value(i_state.floor_code));
        cont_state = '{remaining: i_state.remaining - 3'd1, floor_code: FLOOR_NONE};
    end

    // select by whether a lead byte is expected; errors clear the state
    always_comb begin
        if (i_state.remaining == '0) begin
            o_err   = lead_err;
            o_state = lead_state;
        end else begin
            o_err   = cont_err;
            o_state = cont_state;
        end
        if (o_err) begin
            o_state = '{remaining: '0, floor_code: FLOOR_NONE};
        end
    end

endmodule

### src/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator
// byte-wise UTF-8 checker (six-byte scheme) with per-buffer byte offset
// ----------------------------------------------------------------------------
// Takes one byte per clock while o_ready is high and returns one result per
// byte: status, offset of the byte in its buffer (saturating) and continuation
// bytes still pending. The check is one level of decode between the sequence
// state and the result register, and the block sustains one byte every clock
// while o_ready is high. A two-entry result buffer lets input continue for one
// request while the output side is stalled; o_ready drops only when both
// entries hold results. An unfinished sequence at the end of the stream
// raises no error on its own.
module utf8_stream_validator #(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic [15:0] o_error_offset,
    output logic [2:0]  o_pending_bytes
);
    import u8sv_pkg::*;

    typedef struct packed {
        logic        status;
        logic [15:0] offset;
        logic [2:0]  pending;
    } t_result;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    t_seq_state             r_state, n_state;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [OFFSET_BITS-1:0] cur_off;
    logic [15:0]            cur_off_out;
    logic                   dec_err;
    logic                   accept;
    t_result                new_res;

    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    assign accept = i_valid && o_ready;

    // byte decode
    u8sv_decode u_decode (
        .i_data_byte (i_data_byte),
        .i_state     (r_state),
        .o_err       (dec_err),
        .o_state     (n_state)
    );

    // offset of this byte and of the next one
    always_comb begin
        cur_off  = i_buffer_start ? '0 : r_offset;
        n_offset = (cur_off != OFF_MAX) ? cur_off + OFFSET_BITS'(1) : cur_off;
    end

    // clamp the offset to the result width
    generate
        if (OFFSET_BITS < 16) begin : g_off_narrow
            assign cur_off_out = {{(16 - OFFSET_BITS){1'b0}}, cur_off};
        end else if (OFFSET_BITS == 16) begin : g_off_equal
            assign cur_off_out = cur_off[15:0];
        end else begin : g_off_wide
            assign cur_off_out = (cur_off[OFFSET_BITS-1:16] != '0) ? 16'hFFFF
                                                                   : cur_off[15:0];
        end
    endgenerate

    assign new_res = '{status: dec_err, offset: cur_off_out, pending: n_state.remaining};

    // sequence state and offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '{remaining: '0, floor_code: FLOOR_NONE};
            r_offset <= '0;
        end else if (accept) begin
            r_state  <= n_state;
            r_offset <= n_offset;
        end
    end

    // two-entry result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || i_ready) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= accept;
                end else begin
                    r_out_valid  <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // result payload moves
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (accept) r_skid <= new_res;
            end else if (accept) begin
                r_out <= new_res;
            end
        end else if (accept) begin
            r_skid <= new_res;
        end
    end

    assign o_ready         = !r_skid_valid;
    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_error_offset  = r_out.offset;
    assign o_pending_bytes = r_out.pending;

endmodule

### src/u8sv_checker.sv
// ----------------------------------------------------------------------------
// u8sv_checker
// port-level assertions for the validator, bound to the top level
// ----------------------------------------------------------------------------
`include "utf8_stream_validator_assert.svh"

module u8sv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_buffer_start,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_status,
    input logic [15:0] o_error_offset,
    input logic [2:0]  o_pending_bytes
);

    // a stalled result holds
    `U8SV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_error_offset) && $stable(o_pending_bytes), "result changed while stalled")

    // an error leaves no pending sequence
    `U8SV_ASSERT_IMPL(a_err_clears, i_clk, i_rst_n, o_valid && o_status, o_pending_bytes == 3'd0, "pending count after error")

    // at most five continuation bytes may be pending
    `U8SV_ASSERT_IMPL(a_pending_max, i_clk, i_rst_n, o_valid, o_pending_bytes <= 3'd5, "pending count out of range")

    // no result right after reset
    `U8SV_ASSERT_IMPL(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_valid, "result present after reset")

endmodule

bind utf8_stream_validator u8sv_checker u_u8sv_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the byte-wise UTF-8 stream checker
// ----------------------------------------------------------------------------
// Bytes go in one request at a time with random bursts and gaps, while the
// result side stalls on a changing pattern. A scoreboard class predicts status,
// buffer offset and pending count for every accepted byte, then compares each
// result in order. Stimulus covers every lead byte class, the overlong floors,
// broken and truncated sequences and buffer starts inside a sequence.
module tb;
    import u8sv_pkg::*;

    localparam int unsigned OFFSET_MAX    = 16'hFFFF;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int unsigned RANDOM_BYTES  = 600;
    localparam int unsigned OPENING_COUNT = 27;

    typedef struct {
        logic        status;
        logic [15:0] offset;
        logic [2:0]  pending;
    } t_byte_verdict;

    typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} t_rx_mode;

    // predicts the checker and matches results against it in order
    class verdict_board;
        logic [2:0]    seq_left;
        t_floor        floor_code;
        int unsigned   next_offset;
        t_byte_verdict expected_q[$];
        int unsigned   mismatches;
        int unsigned   checked;
        int unsigned   rejects;

        function new();
            seq_left    = '0;
            floor_code  = FLOOR_NONE;
            next_offset = 0;
            mismatches  = 0;
            checked     = 0;
            rejects     = 0;
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        function void note_request(logic [7:0] b, logic start);
            int unsigned   off;
            logic          bad;
            logic [7:0]    lowest;
            t_byte_verdict v;
            off = start ? 0 : next_offset;
            bad = 1'b0;
            if (seq_left == 0) begin
                // a lead byte is expected
                floor_code = FLOOR_NONE;
                if (b < LEAD_ASCII_END) begin
                    seq_left = 3'd0;
                end else if (b < LEAD_MIN) begin
                    bad = 1'b1;
                end else if (b < LEAD_3B) begin
                    seq_left = 3'd1;
                end else if (b < LEAD_4B) begin
                    seq_left = 3'd2;
                    if (b == LEAD_3B) floor_code = FLOOR_A0;
                end else if (b < LEAD_5B) begin
                    seq_left = 3'd3;
                    if (b == LEAD_4B) floor_code = FLOOR_90;
                end else if (b < LEAD_6B) begin
                    seq_left = 3'd4;
                    if (b == LEAD_5B) floor_code = FLOOR_88;
                end else if (b < LEAD_BAD) begin
                    seq_left = 3'd5;
                    if (b == LEAD_6B) floor_code = FLOOR_84;
                end else begin
                    bad = 1'b1;
                end
            end else begin
                // continuation byte, with the overlong floor on the second one
                case (floor_code)
                    FLOOR_A0: lowest = 8'hA0;
                    FLOOR_90: lowest = 8'h90;
                    FLOOR_88: lowest = 8'h88;
                    FLOOR_84: lowest = 8'h84;
                    default:  lowest = 8'h00;
                endcase
                if ((b & 8'hC0) != 8'h80 || b < lowest) begin
                    bad = 1'b1;
                end else begin
                    seq_left   = seq_left - 3'd1;
                    floor_code = FLOOR_NONE;
                end
            end
            if (bad) begin
                seq_left   = '0;
                floor_code = FLOOR_NONE;
                rejects++;
            end
            v.status  = bad;
            v.offset  = off[15:0];
            v.pending = seq_left;
            expected_q.push_back(v);
            next_offset = (off < OFFSET_MAX) ? off + 1 : OFFSET_MAX;
        endfunction

        function void check_result(logic st, logic [15:0] off, logic [2:0] pend);
            t_byte_verdict want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with no byte outstanding (status %0d offset %0d pending %0d)",
                         $time, st, off, pend);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (st !== want.status) begin
                mismatches++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, st);
            end
            if (off !== want.offset) begin
                mismatches++;
                $display("%0t: error_offset mismatch, expected %0d, actual %0d",
                         $time, want.offset, off);
            end
            if (pend !== want.pending) begin
                mismatches++;
                $display("%0t: pending_bytes mismatch, expected %0d, actual %0d",
                         $time, want.pending, pend);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_buffer_start = 1'b0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_status;
    logic [15:0] o_error_offset;
    logic [2:0]  o_pending_bytes;

    verdict_board board;
    int unsigned  cycle_count = 0;
    int unsigned  bytes_sent  = 0;
    int unsigned  burst_left  = 0;
    t_rx_mode     rx_mode     = RX_OPEN;
    int unsigned  rx_left     = 0;
    int unsigned  rx_phase    = 0;
    int unsigned  rx_hold     = 0;

    logic [7:0] opening [OPENING_COUNT] = '{
        8'h00, 8'h7F, 8'h80, 8'hBF, 8'hC0, 8'hC1, 8'hFE, 8'hFF,
        8'hE0, 8'h9F, 8'hE0, 8'hA0, 8'hBF, 8'hF0, 8'h8F, 8'hF8, 8'h87,
        8'hFC, 8'h83, 8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80,
        8'hC2, 8'h41
    };

    utf8_stream_validator #(
        .OFFSET_BITS(16)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_buffer_start (i_buffer_start),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_error_offset (o_error_offset),
        .o_pending_bytes(o_pending_bytes)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // both handshakes sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid === 1'b1 && o_ready === 1'b1)
                board.note_request(i_data_byte, i_buffer_start);
            if (o_valid === 1'b1 && i_ready === 1'b1)
                board.check_result(o_status, o_error_offset, o_pending_bytes);
        end
    end

    // result side stalls on a randomly changing pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(40, 200);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:     i_ready <= 1'b1;
            RX_COIN:     i_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: i_ready <= (rx_phase % 7) >= 2;
            default: begin
                if (rx_hold != 0) begin
                    rx_hold--;
                    i_ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    rx_hold = $urandom_range(1, 10);
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still awaited",
                     $time, cycle_count, board.outstanding());
            $display("simulation failed");
            $finish;
        end
    end

    // one request; a new burst, sometimes after a gap, starts when the current one is used up
    task automatic put_byte(input logic [7:0] b, input logic start);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_data_byte    <= b;
        i_buffer_start <= start;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // stop sending until every result is back
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (board.outstanding() != 0) @(negedge i_clk);
    endtask

    function automatic bit coin_start(input bit allow);
        return allow && $urandom_range(0, 19) == 0;
    endfunction

    // lead byte for a sequence of n bytes, floor leads favored
    function automatic logic [7:0] pick_lead(input int unsigned n);
        bit edge_lead;
        edge_lead = $urandom_range(0, 2) == 0;
        case (n)
            1:       return 8'($urandom_range(8'h00, 8'h7F));
            2:       return 8'($urandom_range(8'hC2, 8'hDF));
            3:       return edge_lead ? LEAD_3B : 8'($urandom_range(8'hE0, 8'hEF));
            4:       return edge_lead ? LEAD_4B : 8'($urandom_range(8'hF0, 8'hF7));
            5:       return edge_lead ? LEAD_5B : 8'($urandom_range(8'hF8, 8'hFB));
            default: return edge_lead ? LEAD_6B : 8'($urandom_range(8'hFC, 8'hFD));
        endcase
    endfunction

    // lowest legal second byte after a lead
    function automatic logic [7:0] lowest_second(input logic [7:0] lead);
        case (lead)
            LEAD_3B: return FLOOR_VAL_A0;
            LEAD_4B: return FLOOR_VAL_90;
            LEAD_5B: return FLOOR_VAL_88;
            LEAD_6B: return FLOOR_VAL_84;
            default: return CONT_PAT;
        endcase
    endfunction

    // legal continuation byte, often at either end of the range
    function automatic logic [7:0] cont_byte(input logic [7:0] lo);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return 8'hBF;
            default: return 8'($urandom_range(lo, 8'hBF));
        endcase
    endfunction

    // well-formed character of n bytes
    task automatic put_char(input int unsigned n, input bit allow_start);
        logic [7:0]  lead;
        int unsigned k;
        lead = pick_lead(n);
        put_byte(lead, coin_start(allow_start));
        for (k = 1; k < n; k++)
            put_byte(cont_byte(k == 1 ? lowest_second(lead) : CONT_PAT), coin_start(allow_start));
    endtask

    // sequence cut short or spoiled by one bad byte
    task automatic put_broken();
        logic [7:0]  lead;
        logic [7:0]  lo;
        int unsigned n;
        int unsigned k;
        int unsigned i;
        n = $urandom_range(2, 6);
        lead = pick_lead(n);
        lo = lowest_second(lead);
        put_byte(lead, coin_start(1));
        k = $urandom_range(0, n - 2);
        for (i = 1; i <= k; i++)
            put_byte(cont_byte(i == 1 ? lo : CONT_PAT), coin_start(1));
        case ($urandom_range(0, 2))
            0:       put_byte(8'($urandom_range(8'h00, 8'h7F)), coin_start(1));
            1:       put_byte(8'($urandom_range(8'hC0, 8'hFF)), coin_start(1));
            default: put_byte((k == 0 && lo != CONT_PAT) ? lo - 8'd1
                                                         : 8'($urandom_range(0, 255)),
                              coin_start(1));
        endcase
    endtask

    initial begin
        int unsigned i;
        int unsigned first_random;
        int unsigned pick;
        board = new();

        // synchronous reset
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every lead class, floors, recovery, buffer start mid-sequence
        for (i = 0; i < OPENING_COUNT; i++)
            put_byte(opening[i], i == 0 || i == 11 || i == 21);

        // random mix, mostly well-formed characters
        first_random = bytes_sent;
        while (bytes_sent - first_random < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                put_char($urandom_range(1, 6), 1);
            else if (pick < 88)
                put_broken();
            else
                put_byte(8'($urandom_range(0, 255)), coin_start(1));
        end

        // let everything come back before the tail
        drain();

        // a short tail, new buffers again
        for (i = 0; i < 40; i++)
            put_char($urandom_range(1, 6), 1);

        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d bytes, %0d results checked, %0d rejected as illegal",
                 bytes_sent, board.checked, board.rejects);
        if (board.outstanding() != 0)
            $display("%0t: %0d results never arrived", $time, board.outstanding());
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/u8sv_pkg.sv
src/u8sv_decode.sv
src/utf8_stream_validator.sv
src/u8sv_checker.sv
tb/sv/tb.sv
